@@ rtl/core/dasp_pkg.sv @@
// Shared types, constants and sentence-pattern functions for the
// depth/attitude sentence parser. No dependencies.
package dasp_pkg;

    localparam int FRAME_LIMIT = 256;
    localparam int BC_W = $clog2(FRAME_LIMIT + 1);
    localparam int CMP_W = (BC_W > 8) ? BC_W : 8;
    localparam logic [7:0] MIN_LEN_RESET = 8'd20;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_H      = 8'h48;

    localparam logic [1:0] ST_UNKNOWN = 2'd0;
    localparam logic [1:0] ST_DEPTH   = 2'd1;
    localparam logic [1:0] ST_ATT     = 2'd2;

    localparam logic [2:0] NP_BEFORE = 3'd0;
    localparam logic [2:0] NP_SIGN   = 3'd1;
    localparam logic [2:0] NP_INT    = 3'd2;
    localparam logic [2:0] NP_POINT  = 3'd3;
    localparam logic [2:0] NP_FRAC   = 3'd4;
    localparam logic [2:0] NP_TAKEN  = 3'd5;

    localparam logic [1:0] KIND_DEPTH  = 2'd0;
    localparam logic [1:0] KIND_ATT    = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;
    localparam logic [1:0] KIND_TICK   = 2'd3;

    localparam logic [4:0] STEP_TYPE = 5'd2;
    localparam logic [4:0] LEN_DEPTH = 5'd15;
    localparam logic [4:0] LEN_ATT   = 5'd11;

    typedef struct packed {
        logic [1:0]        stype;
        logic [4:0]        step;
        logic              neg;
        logic [2:0]        nphase;
        logic [15:0]       acc;
        logic [2:0][15:0]  vals;
        logic              failed;
    } parser_t;

    localparam parser_t PARSER_CLEAR = '0;

    function automatic logic [4:0] pat_len(input logic [1:0] stype);
        return (stype == ST_ATT) ? LEN_ATT : LEN_DEPTH;
    endfunction

    // "ISDPT,#,M,#,B,#" or "ISHPR,#,#,#"; zero past the end
    function automatic logic [7:0] pat_char(input logic [1:0] stype, input logic [4:0] step);
        logic [7:0] c;
        c = 8'h00;
        if (stype == ST_ATT) begin
            case (step)
                5'd0: c = 8'h49;
                5'd1: c = 8'h53;
                5'd2: c = 8'h48;
                5'd3: c = 8'h50;
                5'd4: c = 8'h52;
                5'd5, 5'd7, 5'd9: c = 8'h2C;
                5'd6, 5'd8, 5'd10: c = CH_HASH;
                default: c = 8'h00;
            endcase
        end else begin
            case (step)
                5'd0: c = 8'h49;
                5'd1: c = 8'h53;
                5'd2: c = 8'h44;
                5'd3: c = 8'h50;
                5'd4: c = 8'h54;
                5'd5, 5'd7, 5'd9, 5'd11, 5'd13: c = 8'h2C;
                5'd6, 5'd10, 5'd14: c = CH_HASH;
                5'd8: c = 8'h4D;
                5'd12: c = 8'h42;
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

    function automatic logic [1:0] cap_idx(input logic [1:0] stype, input logic [4:0] step);
        logic [1:0] k;
        k = 2'd0;
        if (stype == ST_ATT) begin
            case (step)
                5'd8:    k = 2'd1;
                5'd10:   k = 2'd2;
                default: k = 2'd0;
            endcase
        end else begin
            case (step)
                5'd10:   k = 2'd1;
                5'd14:   k = 2'd2;
                default: k = 2'd0;
            endcase
        end
        return k;
    endfunction

    function automatic logic parse_done(input parser_t p);
        return (p.stype != ST_UNKNOWN) && (p.step >= pat_len(p.stype));
    endfunction

    // one character through the sentence parser
    function automatic parser_t feed(input parser_t p, input logic [7:0] ch);
        parser_t     r;
        logic        digit;
        logic        ws;
        logic        finish;
        logic        lit;
        logic [15:0] d;
        logic [15:0] acc10;
        logic [15:0] fin_acc;
        logic [7:0]  c;
        r       = p;
        digit   = (ch >= CH_ZERO) && (ch <= CH_NINE);
        ws      = (ch == CH_SPACE) || ((ch >= 8'd9) && (ch <= 8'd13));
        d       = {12'd0, ch[3:0]};
        acc10   = (p.acc << 3) + (p.acc << 1);
        fin_acc = p.acc;
        finish  = 1'b0;
        lit     = 1'b0;
        c       = pat_char(p.stype, p.step);
        if (p.failed || parse_done(p)) begin
            r = p;
        end else if (p.step == STEP_TYPE) begin
            if (ch == CH_D) r.stype = ST_DEPTH;
            else if (ch == CH_H) r.stype = ST_ATT;
            else r.failed = 1'b1;
            r.step = p.step + 5'd1;
        end else begin
            if (c == CH_HASH) begin
                case (p.nphase)
                    NP_BEFORE, NP_SIGN: begin
                        if (p.nphase == NP_BEFORE && ws) begin
                            r.nphase = NP_BEFORE;
                        end else if (p.nphase == NP_BEFORE && ch == CH_PLUS) begin
                            r.nphase = NP_SIGN;
                        end else if (p.nphase == NP_BEFORE && ch == CH_MINUS) begin
                            r.neg    = 1'b1;
                            r.nphase = NP_SIGN;
                        end else if (digit) begin
                            r.acc    = d;
                            r.nphase = NP_INT;
                        end else if (ch == CH_POINT) begin
                            r.nphase = NP_POINT;
                        end else begin
                            r.failed = 1'b1;
                        end
                    end
                    NP_INT: begin
                        if (digit) begin
                            r.acc = acc10 + d;
                        end else if (ch == CH_POINT) begin
                            r.acc    = acc10;
                            r.nphase = NP_FRAC;
                        end else begin
                            fin_acc = acc10;
                            finish  = 1'b1;
                        end
                    end
                    NP_POINT: begin
                        if (digit) begin
                            r.acc    = acc10 + d;
                            r.nphase = NP_TAKEN;
                        end else begin
                            r.failed = 1'b1;
                        end
                    end
                    NP_FRAC: begin
                        if (digit) begin
                            r.acc    = p.acc + d;
                            r.nphase = NP_TAKEN;
                        end else begin
                            finish = 1'b1;
                        end
                    end
                    NP_TAKEN: begin
                        if (!digit) finish = 1'b1;
                    end
                    default: begin
                        r.failed = 1'b1;
                    end
                endcase
                if (finish) begin
                    r.vals[cap_idx(p.stype, p.step)] = p.neg ? (16'd0 - fin_acc) : fin_acc;
                    r.neg    = 1'b0;
                    r.nphase = NP_BEFORE;
                    r.acc    = '0;
                    r.step   = p.step + 5'd1;
                    if (!parse_done(r)) begin
                        c   = pat_char(r.stype, r.step);
                        lit = 1'b1;
                    end
                end
            end else begin
                lit = 1'b1;
            end
            if (lit) begin
                if (c == ch && ch != 8'h00) r.step = r.step + 5'd1;
                else r.failed = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/core/depth_attitude_sentence_parser.sv @@
// Depth/attitude sentence parser: frames serial bytes, parses fields on the fly.
// Depends on dasp_pkg.
// A request is captured in the input register; its result is then captured in the result register.
// Throughput: one request per cycle while results are taken; a waiting result stalls the input register.
// Frame close and poll ticks each give one result; other bytes give none.
// Reset: aresetn synchronous, active low; clears framing, parser, miss count, min length 20.
module depth_attitude_sentence_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_result_kind,
    output logic signed [15:0] m_first_value,
    output logic signed [15:0] m_second_value,
    output logic signed [15:0] m_third_value,
    output logic [15:0]        m_missed_polls
);
    import dasp_pkg::*;

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_COLLECT = 2'd1;
    localparam logic [1:0] PH_CLOSED  = 2'd2;

    logic            in_valid_reg;
    logic            mode_reg;
    logic [7:0]      byte_reg;
    logic [7:0]      min_len_reg;
    logic [1:0]      phase_reg, phase_next;
    logic [BC_W-1:0] bc_reg, bc_next;
    parser_t         ps_reg, ps_next;
    logic [15:0]     miss_reg, miss_next;

    logic            out_valid_reg;
    logic [1:0]      kind_reg, kind_next;
    logic [15:0]     v0_reg, v0_next, v1_reg, v1_next, v2_reg, v2_next;
    logic [15:0]     polls_reg, polls_next;
    logic            emit;

    logic            adv;
    parser_t         fed;
    logic [BC_W-1:0] bc_inc;
    logic            close_hit;

    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;

    assign fed       = feed(ps_reg, close_hit ? CH_STAR : byte_reg);
    assign bc_inc    = bc_reg + {{(BC_W-1){1'b0}}, 1'b1};
    assign close_hit = (byte_reg == CH_STAR) &&
                       (CMP_W'(bc_reg) > CMP_W'(min_len_reg));

    always_comb begin
        phase_next = phase_reg;
        bc_next    = bc_reg;
        ps_next    = ps_reg;
        miss_next  = miss_reg;
        emit       = 1'b0;
        kind_next  = KIND_REJECT;
        v0_next    = '0;
        v1_next    = '0;
        v2_next    = '0;
        polls_next = '0;
        if (mode_reg) begin
            miss_next  = miss_reg + ((phase_reg != PH_CLOSED) ? 16'd1 : 16'd0);
            emit       = 1'b1;
            kind_next  = KIND_TICK;
            polls_next = miss_next;
            phase_next = PH_HUNT;
            bc_next    = '0;
            ps_next    = PARSER_CLEAR;
        end else if (phase_reg == PH_COLLECT) begin
            if (close_hit) begin
                ps_next    = fed;
                phase_next = PH_CLOSED;
                emit       = 1'b1;
                if (!fed.failed && parse_done(fed)) begin
                    kind_next = (fed.stype == ST_ATT) ? KIND_ATT : KIND_DEPTH;
                    v0_next   = fed.vals[0];
                    v1_next   = fed.vals[1];
                    v2_next   = fed.vals[2];
                end
            end else begin
                ps_next = fed;
                bc_next = bc_inc;
                if (bc_inc >= BC_W'(FRAME_LIMIT)) begin
                    phase_next = PH_HUNT;
                    bc_next    = '0;
                    ps_next    = PARSER_CLEAR;
                    if (byte_reg == CH_DOLLAR) begin
                        phase_next = PH_COLLECT;
                        bc_next    = BC_W'(1);
                    end
                end
            end
        end else if (phase_reg == PH_HUNT && byte_reg == CH_DOLLAR) begin
            phase_next = PH_COLLECT;
            bc_next    = BC_W'(1);
            ps_next    = PARSER_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            min_len_reg   <= MIN_LEN_RESET;
            phase_reg     <= PH_HUNT;
            bc_reg        <= '0;
            ps_reg        <= PARSER_CLEAR;
            miss_reg      <= '0;
        end else begin
            if (cfg_we) min_len_reg <= cfg_wdata;
            if (s_valid && s_ready) in_valid_reg <= 1'b1;
            else if (adv) in_valid_reg <= 1'b0;
            if (adv) begin
                phase_reg <= phase_next;
                bc_reg    <= bc_next;
                ps_reg    <= ps_next;
                miss_reg  <= miss_next;
            end
            if (adv && emit) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg <= s_mode;
            byte_reg <= s_rx_byte;
        end
        if (adv && emit) begin
            kind_reg  <= kind_next;
            v0_reg    <= v0_next;
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
            polls_reg <= polls_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_result_kind  = kind_reg;
    assign m_first_value  = $signed(v0_reg);
    assign m_second_value = $signed(v1_reg);
    assign m_third_value  = $signed(v2_reg);
    assign m_missed_polls = polls_reg;

    a_bc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_COLLECT) |-> (bc_reg != '0 && bc_reg < BC_W'(FRAME_LIMIT)))
        else $error("byte count out of range while collecting");

    a_tick_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && mode_reg) |=> (m_valid && m_result_kind == KIND_TICK))
        else $error("poll tick gave no tick result");

    a_polls_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind != KIND_TICK) |-> (m_missed_polls == 16'd0))
        else $error("missed poll count on frame result");

    a_values_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_kind == KIND_TICK || m_result_kind == KIND_REJECT)) |->
        (v0_reg == 16'd0 && v1_reg == 16'd0 && v2_reg == 16'd0))
        else $error("values nonzero on tick or reject");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ps_reg.step <= LEN_DEPTH)
        else $error("parse step past pattern end");

endmodule

@@ test/tb_depth_attitude_sentence_parser.sv @@
// Self-checking testbench for depth_attitude_sentence_parser: serial byte and poll tick
// requests in, parsed frame and tick reports out, checked against an in-bench predictor.
// Depends on dasp_pkg and the parser RTL.
module tb_depth_attitude_sentence_parser;
    import dasp_pkg::*;

    localparam int RUN_LIMIT   = 20_000_000;
    localparam int HOLD_CYCLES = 120;

    typedef enum logic [1:0] {RX_HUNT, RX_COLLECT, RX_CLOSED} rx_phase_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx;
    } serial_req_t;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] first_v;
        logic [15:0] second_v;
        logic [15:0] third_v;
        logic [15:0] misses;
    } report_t;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [7:0]         cfg_wdata = 8'd0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic               s_mode    = 1'b0;
    logic [7:0]         s_rx_byte = 8'd0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic [1:0]         m_result_kind;
    logic signed [15:0] m_first_value;
    logic signed [15:0] m_second_value;
    logic signed [15:0] m_third_value;
    logic [15:0]        m_missed_polls;

    depth_attitude_sentence_parser i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_first_value  (m_first_value),
        .m_second_value (m_second_value),
        .m_third_value  (m_third_value),
        .m_missed_polls (m_missed_polls)
    );

    // predictor state
    rx_phase_t   rx_phase;
    int unsigned frame_bytes;
    logic [1:0]  sent_type;
    int          sent_step;
    bit          num_neg;
    logic [2:0]  num_phase;
    logic [15:0] num_acc;
    logic [15:0] field_vals [3];
    bit          sent_bad;
    logic [15:0] miss_count;
    logic [7:0]  min_len;

    serial_req_t serial_stream [$];
    report_t     awaited_reports [$];
    logic [7:0]  frame_text [$];

    int  mismatches;
    int  queued_requests;
    int  reports_predicted;
    int  kind_seen [4];
    int  overflows;
    int  mid_len;
    int  low_len;
    bit  idle_enabled;
    bit  req_taken;
    bit  hold_request;
    int  hold_left;
    int  stall_left;
    int  send_gap;
    serial_req_t next_req;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("timeout at %0t, %0d reports outstanding", $time, awaited_reports.size());
        $display("depth_attitude_sentence_parser regression: fail");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic logic [7:0] pattern_char(input int step);
        string p;
        if (sent_type == ST_ATT) p = "ISHPR,#,#,#";
        else p = "ISDPT,#,M,#,B,#";
        if (step >= p.len()) return 8'h00;
        return p[step];
    endfunction

    function automatic bit sentence_complete();
        int plen;
        plen = (sent_type == ST_ATT) ? 11 : 15;
        return sent_type != ST_UNKNOWN && sent_step >= plen;
    endfunction

    function automatic int field_slot(input int step);
        int k;
        k = 0;
        for (int i = 0; i < step; i++)
            if (pattern_char(i) == CH_HASH) k++;
        return k % 3;
    endfunction

    function automatic void clear_sentence();
        sent_type = ST_UNKNOWN;
        sent_step = 0;
        num_neg = 1'b0;
        num_phase = NP_BEFORE;
        num_acc = 16'd0;
        field_vals[0] = 16'd0;
        field_vals[1] = 16'd0;
        field_vals[2] = 16'd0;
        sent_bad = 1'b0;
    endfunction

    function automatic void feed_char(input logic [7:0] ch);
        logic [7:0]  lit;
        logic [15:0] d;
        logic [15:0] val;
        bit          is_digit;
        bit          finish;
        if (sent_bad || sentence_complete()) return;
        if (sent_step == STEP_TYPE) begin
            if (ch == CH_D) sent_type = ST_DEPTH;
            else if (ch == CH_H) sent_type = ST_ATT;
            else sent_bad = 1'b1;
            sent_step++;
            return;
        end
        is_digit = ch >= CH_ZERO && ch <= CH_NINE;
        d = {8'd0, ch} - {8'd0, CH_ZERO};
        val = num_acc;
        finish = 1'b0;
        lit = pattern_char(sent_step);
        if (lit == CH_HASH) begin
            case (num_phase)
                NP_BEFORE, NP_SIGN: begin
                    if (num_phase == NP_BEFORE &&
                        (ch == CH_SPACE || (ch >= 8'd9 && ch <= 8'd13))) return;
                    if (num_phase == NP_BEFORE && ch == CH_PLUS) begin
                        num_phase = NP_SIGN;
                        return;
                    end
                    if (num_phase == NP_BEFORE && ch == CH_MINUS) begin
                        num_neg = 1'b1;
                        num_phase = NP_SIGN;
                        return;
                    end
                    if (is_digit) begin
                        num_acc = d;
                        num_phase = NP_INT;
                    end else if (ch == CH_POINT) begin
                        num_phase = NP_POINT;
                    end else begin
                        sent_bad = 1'b1;
                    end
                    return;
                end
                NP_INT: begin
                    if (is_digit) begin
                        num_acc = num_acc * 16'd10 + d;
                        return;
                    end
                    if (ch == CH_POINT) begin
                        num_acc = num_acc * 16'd10;
                        num_phase = NP_FRAC;
                        return;
                    end
                    val = num_acc * 16'd10;
                    finish = 1'b1;
                end
                NP_POINT: begin
                    if (is_digit) begin
                        num_acc = num_acc * 16'd10 + d;
                        num_phase = NP_TAKEN;
                    end else begin
                        sent_bad = 1'b1;
                    end
                    return;
                end
                NP_FRAC: begin
                    if (is_digit) begin
                        num_acc = num_acc + d;
                        num_phase = NP_TAKEN;
                        return;
                    end
                    finish = 1'b1;
                end
                default: begin
                    if (is_digit) return;
                    finish = 1'b1;
                end
            endcase
            if (num_neg) val = 16'd0 - val;
            field_vals[field_slot(sent_step)] = val;
            num_neg = 1'b0;
            num_phase = NP_BEFORE;
            num_acc = 16'd0;
            sent_step++;
            if (sentence_complete()) return;
            lit = pattern_char(sent_step);
        end
        if (lit == ch && ch != 8'h00) sent_step++;
        else sent_bad = 1'b1;
    endfunction

    function automatic void parse_request(input logic mode, input logic [7:0] ch);
        report_t rep;
        rep.kind = KIND_TICK;
        rep.first_v = 16'd0;
        rep.second_v = 16'd0;
        rep.third_v = 16'd0;
        rep.misses = 16'd0;
        if (mode) begin
            if (rx_phase != RX_CLOSED) miss_count++;
            rep.misses = miss_count;
            awaited_reports.push_back(rep);
            reports_predicted++;
            rx_phase = RX_HUNT;
            frame_bytes = 0;
            clear_sentence();
        end else if (rx_phase == RX_COLLECT) begin
            if (ch == CH_STAR && frame_bytes > min_len) begin
                feed_char(CH_STAR);
                feed_char(8'h00);
                rx_phase = RX_CLOSED;
                if (!sent_bad && sentence_complete()) begin
                    rep.kind = (sent_type == ST_DEPTH) ? KIND_DEPTH : KIND_ATT;
                    rep.first_v = field_vals[0];
                    rep.second_v = field_vals[1];
                    rep.third_v = field_vals[2];
                end else begin
                    rep.kind = KIND_REJECT;
                end
                awaited_reports.push_back(rep);
                reports_predicted++;
            end else begin
                feed_char(ch);
                frame_bytes++;
                if (frame_bytes >= FRAME_LIMIT) begin
                    rx_phase = RX_HUNT;
                    frame_bytes = 0;
                    clear_sentence();
                    if (ch == CH_DOLLAR) begin
                        rx_phase = RX_COLLECT;
                        frame_bytes = 1;
                    end
                end
            end
        end else if (rx_phase == RX_HUNT && ch == CH_DOLLAR) begin
            rx_phase = RX_COLLECT;
            frame_bytes = 1;
            clear_sentence();
        end
    endfunction

    // ---------------- checking ----------------

    function automatic void check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_report();
        report_t want;
        if (awaited_reports.size() == 0) begin
            $display("%0t: unexpected report, expected none, got kind %0d",
                     $time, m_result_kind);
            mismatches++;
            return;
        end
        want = awaited_reports.pop_front();
        kind_seen[want.kind]++;
        check_field("result_kind", int'(want.kind), int'(m_result_kind));
        check_field("first_value", int'($signed(want.first_v)), int'(m_first_value));
        check_field("second_value", int'($signed(want.second_v)), int'(m_second_value));
        check_field("third_value", int'($signed(want.third_v)), int'(m_third_value));
        check_field("missed_polls", int'(want.misses), int'(m_missed_polls));
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) check_report();
            if (s_valid && s_ready) begin
                parse_request(s_mode, s_rx_byte);
                req_taken = 1'b1;
            end
        end
    end

    // ---------------- driver and receiver ----------------

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            req_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (serial_stream.size() != 0) begin
                next_req = serial_stream.pop_front();
                s_valid   <= 1'b1;
                s_mode    <= next_req.mode;
                s_rx_byte <= next_req.rx;
                send_gap = idle_enabled ? idle_length() : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            stall_left = idle_enabled ? idle_length() : 0;
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------- stimulus ----------------

    function automatic void queue_byte(input logic [7:0] b);
        serial_req_t q;
        q.mode = 1'b0;
        q.rx = b;
        serial_stream.push_back(q);
        queued_requests++;
    endfunction

    function automatic void queue_tick();
        serial_req_t q;
        q.mode = 1'b1;
        q.rx = 8'($urandom_range(0, 255));
        serial_stream.push_back(q);
        queued_requests++;
    endfunction

    function automatic void queue_text(input string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
    endfunction

    function automatic void queue_frame();
        foreach (frame_text[i]) queue_byte(frame_text[i]);
    endfunction

    function automatic logic [7:0] filler_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_STAR) b = CH_SPACE;
        return b;
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) frame_text.push_back(s[i]);
    endfunction

    function automatic void add_digits(input int n);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            c = CH_ZERO + 8'($urandom_range(0, 9));
            frame_text.push_back(c);
        end
    endfunction

    function automatic void add_number();
        int         r;
        int         n_int;
        logic [7:0] c;
        if ($urandom_range(0, 9) < 2) begin
            repeat ($urandom_range(1, 2)) begin
                c = $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13));
                frame_text.push_back(c);
            end
        end
        r = $urandom_range(0, 9);
        if (r < 2) frame_text.push_back(CH_PLUS);
        else if (r < 4) frame_text.push_back(CH_MINUS);
        r = $urandom_range(0, 19);
        n_int = (r < 2) ? 0 : (r < 17) ? $urandom_range(1, 3) : $urandom_range(4, 6);
        add_digits(n_int);
        if (n_int == 0 || $urandom_range(0, 1) == 1) begin
            frame_text.push_back(CH_POINT);
            add_digits((n_int == 0) ? $urandom_range(1, 3) : $urandom_range(0, 3));
        end
    endfunction

    function automatic void build_sentence(input logic [7:0] type_char);
        frame_text.delete();
        frame_text.push_back(CH_DOLLAR);
        add_text("IS");
        frame_text.push_back(type_char);
        if (type_char == CH_H) begin
            add_text("PR,");
            add_number();
            add_text(",");
            add_number();
            add_text(",");
            add_number();
        end else begin
            add_text("PT,");
            add_number();
            add_text(",M,");
            add_number();
            add_text(",B,");
            add_number();
        end
    endfunction

    // frame must hold more than min_len bytes before its closing star counts
    function automatic void pad_frame();
        if (min_len < 200)
            while (frame_text.size() <= min_len) frame_text.push_back(filler_byte());
    endfunction

    task automatic random_sequence();
        int         pick;
        int         cut;
        logic [7:0] dropped;
        logic [7:0] tc;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            repeat ($urandom_range(1, 10)) queue_byte(8'($urandom_range(0, 255)));
        end else if (pick < 10) begin
            repeat ($urandom_range(0, 2)) queue_tick();
        end else if (pick < 12 && overflows < 1) begin
            // oversized frame; half of them end on a dollar that opens a fresh frame
            overflows++;
            queue_byte(CH_DOLLAR);
            repeat (FRAME_LIMIT - 2) queue_byte(filler_byte());
            if ($urandom_range(0, 1)) begin
                build_sentence($urandom_range(0, 1) ? CH_D : CH_H);
                pad_frame();
                queue_frame();
                queue_byte(CH_STAR);
            end else begin
                queue_byte(filler_byte());
            end
        end else begin
            tc = $urandom_range(0, 1) ? CH_D : CH_H;
            if (pick < 15) tc = filler_byte();
            build_sentence(tc);
            pad_frame();
            if (pick >= 15 && pick < 25) begin
                frame_text[$urandom_range(1, frame_text.size() - 1)] =
                    8'($urandom_range(0, 255));
            end else if (pick >= 25 && pick < 40) begin
                cut = $urandom_range(1, frame_text.size() - 1);
                while (frame_text.size() > cut) dropped = frame_text.pop_back();
            end else if (pick >= 40 && pick < 45) begin
                frame_text[$urandom_range(1, frame_text.size() - 1)] = 8'h00;
            end
            queue_frame();
            // truncated frames from 33 up are left open for the tick to drop
            if (pick < 33 || pick >= 40) begin
                queue_byte(CH_STAR);
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
            end
        end
        queue_tick();
    endtask

    task automatic random_phase(input int n_items, input int n_reports);
        int start_items;
        int start_reports;
        start_items = queued_requests;
        start_reports = reports_predicted;
        while (queued_requests - start_items < n_items ||
               reports_predicted - start_reports < n_reports) begin
            idle_enabled = ($urandom_range(0, 4) != 0);
            random_sequence();
            while (serial_stream.size() > 16) @(negedge aclk);
        end
    endtask

    task automatic wait_drained();
        while (serial_stream.size() != 0 || s_valid || awaited_reports.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_min_length(input logic [7:0] v);
        wait_drained();
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(negedge aclk);
        cfg_we <= 1'b0;
        min_len = v;
    endtask

    initial begin
        rx_phase = RX_HUNT;
        frame_bytes = 0;
        miss_count = 16'd0;
        min_len = MIN_LEN_RESET;
        clear_sentence();
        idle_enabled = 1'b1;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: byte extremes while hunting, a miss, two frames at the reset length
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_tick();
        queue_text("$ISHPR, -.5,+6553.5,\t0.99*");
        queue_tick();
        queue_text("$ISDPT,  9,M,-12.34,B,7.*");
        queue_tick();

        random_phase(70, 4);
        set_min_length(8'd0);
        random_phase(70, 4);
        mid_len = $urandom_range(1, 60);
        set_min_length(8'(mid_len));
        random_phase(70, 4);
        set_min_length(8'd255);
        random_phase(40, 2);
        low_len = $urandom_range(0, 30);
        set_min_length(8'(low_len));
        random_phase(70, 4);

        // receiver holds off while ticks keep coming, so the input backs up
        wait_drained();
        idle_enabled = 1'b0;
        hold_request = 1'b1;
        repeat (40) queue_tick();
        wait_drained();

        $display("%0d requests, reports: %0d depth, %0d attitude, %0d rejected, %0d tick",
                 queued_requests, kind_seen[KIND_DEPTH], kind_seen[KIND_ATT],
                 kind_seen[KIND_REJECT], kind_seen[KIND_TICK]);
        $display("min frame lengths 20, 0, %0d, 255, %0d; %0d oversized frames; long hold",
                 mid_len, low_len, overflows);
        if (mismatches == 0) begin
            $display("depth_attitude_sentence_parser regression: pass");
        end else begin
            $display("depth_attitude_sentence_parser regression: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/dasp_pkg.sv
rtl/core/depth_attitude_sentence_parser.sv
test/tb_depth_attitude_sentence_parser.sv
